// ===== rtl/ljpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_pkg
// Types, constants and helpers shared by the pair force accumulator.
// ----------------------------------------------------------------------------
package ljpf_pkg;

  // Saturation limits
  localparam logic [63:0] CEIL62 = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX47  = 64'h0000_7FFF_FFFF_FFFF;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_BOX_LENGTH     = 3'd0;
  localparam logic [2:0] REG_INV_BOX_LENGTH = 3'd1;
  localparam logic [2:0] REG_CUTOFF_SQ      = 3'd2;
  localparam logic [2:0] REG_EPSILON        = 3'd3;
  localparam logic [2:0] REG_ENERGY_SHIFT   = 3'd4;

  // Reciprocal saturates at or below this r2
  localparam logic [63:0] RECIP_SAT_R2 = 64'd1024;

  // Post-processing of the shared multiplier
  typedef enum logic [1:0] {
    MUL_PLAIN,  // low 64 bits of the product
    MUL_SH40,   // >> 40, saturate at CEIL62
    MUL_SH32,   // >> 32, saturate at MAX47
    MUL_SH56    // >> 56, saturate at MAX47
  } mul_mode_t;

  typedef struct packed {
    logic      start;
    mul_mode_t mode;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
  } unit_stat_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_P, S_K, S_SQ, S_CHK, S_DIV,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_F, S_FIN
  } seq_state_t;

  function automatic logic [49:0] mag50(input logic signed [49:0] v);
    mag50 = v[49] ? 50'(-v) : 50'(v);
  endfunction

  function automatic logic [65:0] mag66(input logic signed [65:0] v);
    mag66 = v[65] ? 66'(-v) : 66'(v);
  endfunction

  // 48-bit accumulator add with saturation
  function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                   input logic signed [49:0] b);
    logic signed [50:0] s;
    s = 51'(a) + 51'(b);
    if (s > 51'sh7FFF_FFFF_FFFF)
      sat_add48 = 48'sh7FFF_FFFF_FFFF;
    else if (s < -51'sh8000_0000_0000)
      sat_add48 = 48'sh8000_0000_0000;
    else
      sat_add48 = s[47:0];
  endfunction

endpackage

// ===== rtl/ljpf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_mul
// Shared 64x64 multiplier: four 32x32 partial products, one per cycle,
// then a shift and saturate step.
// ----------------------------------------------------------------------------
module ljpf_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ljpf_pkg::mul_req_t   req,
  input  logic [63:0]          a,
  input  logic [63:0]          b,
  output ljpf_pkg::unit_stat_t stat,
  output logic [63:0]          res
);

  logic [63:0]         a_r, b_r;
  ljpf_pkg::mul_mode_t mode_r;
  logic [127:0]        acc_r, acc_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt, fin_r, fin_nxt;
  logic [31:0]         ap, bp;
  logic [63:0]         pp;
  logic [127:0]        pp_sh;
  logic [127:0]        shv;
  logic [63:0]         lim;

  // partial product select
  always_comb begin
    ap = cnt_r[0] ? a_r[63:32] : a_r[31:0];
    bp = cnt_r[1] ? b_r[63:32] : b_r[31:0];
    pp = 64'(ap) * 64'(bp);
    case (2'(cnt_r[0]) + 2'(cnt_r[1]))
      2'd0:    pp_sh = 128'(pp);
      2'd1:    pp_sh = 128'(pp) << 32;
      default: pp_sh = 128'(pp) << 64;
    endcase
  end

  // sequencing
  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + pp_sh;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    if (req.start) begin
      a_r    <= a;
      b_r    <= b;
      mode_r <= req.mode;
    end
  end

  // shift and saturate
  always_comb begin
    case (mode_r)
      ljpf_pkg::MUL_SH40: begin shv = acc_r >> 40; lim = ljpf_pkg::CEIL62; end
      ljpf_pkg::MUL_SH32: begin shv = acc_r >> 32; lim = ljpf_pkg::MAX47;  end
      ljpf_pkg::MUL_SH56: begin shv = acc_r >> 56; lim = ljpf_pkg::MAX47;  end
      default:            begin shv = acc_r;       lim = '1;               end
    endcase
    if (mode_r == ljpf_pkg::MUL_PLAIN)
      res = acc_r[63:0];
    else if (shv > 128'(lim))
      res = lim;
    else
      res = shv[63:0];
    stat.done = fin_r;
    stat.busy = busy_r | fin_r;
  end

endmodule

// ===== rtl/ljpf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljpf_div
// Restoring divider for floor(2^72 / r2), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ljpf_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          den,
  output ljpf_pkg::unit_stat_t stat,
  output logic [63:0]          quo
);

  logic [63:0] den_r, rem_r, rem_nxt, q_r, q_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] rem_sh;
  logic        qbit;

  always_comb begin
    // dividend is a single one at bit 72
    rem_sh   = {rem_r, (cnt_r == 7'd72)};
    qbit     = rem_sh >= {1'b0, den_r};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = 7'd72;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
      q_nxt   = {q_r[62:0], qbit};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) den_r <= den;
  end

  assign quo       = (q_r > ljpf_pkg::CEIL62) ? ljpf_pkg::CEIL62 : q_r;
  assign stat.done = done_r;
  assign stat.busy = busy_r;

endmodule

// ===== rtl/lj_pair_force_accumulator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lj_pair_force_accumulator_core
// Lennard-Jones pair force and energy accumulator with cutoff and shift.
// ----------------------------------------------------------------------------
// Usage:
//  in_*  : one particle pair per word. in_tdata = home_x, home_y, home_z,
//          nbr_x, nbr_y, nbr_z (Q16.16); in_tlast = last neighbor of the home
//          particle; in_tuser = frame start (clears the frame energy total).
//  out_* : one word per home particle, after its last neighbor: forces,
//          particle energy and frame total, all Q24.24 saturating.
//  cfg_* : register writes (index, data), taken at any time; write only
//          while idle.
//  A pair outside the cutoff takes three wrap and square steps (nine
//  multiplies on the shared multiplier); a pair inside it also runs the
//  reciprocal divider and nine more multiplies, skipping the divider
//  when the reciprocal saturates. Each multiply runs on the one 32x32
//  multiplier. in_tready is high only while the sequencer is idle.
//  A finished result sits in the output register; a stalled receiver
//  holds the next emitting pair in its final step until the register frees.
//  Reset (synchronous, active low) clears accumulators and loads default
//  register values.
// ----------------------------------------------------------------------------
module lj_pair_force_accumulator_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // home_x, home_y, home_z, nbr_x, nbr_y, nbr_z
  input  logic         in_tlast,   // last_neighbor
  input  logic         in_tuser,   // frame_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [239:0] out_tdata,  // force_x, force_y, force_z, particle_energy,
                                   // total_energy
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  // configuration
  logic [30:0]        box_r;
  logic [31:0]        inv_box_r;
  logic [62:0]        cutoff_r;
  logic [31:0]        eps_r;
  logic signed [47:0] eshift_r;

  // sequencer and datapath state
  ljpf_pkg::seq_state_t state_r, state_nxt;
  logic [1:0]           ax_r, ax_nxt;
  logic                 wait_r, wait_nxt;
  logic                 last_r, last_nxt;
  logic signed [49:0]   d_r [3];
  logic signed [49:0]   dcur_nxt;
  logic                 dwr;
  logic [63:0]          p_r, p_nxt, r2_r, r2_nxt, ir2_r, ir2_nxt;
  logic [63:0]          t_r, t_nxt, ir6_r, ir6_nxt, ir12_r, ir12_nxt, fm_r, fm_nxt;
  logic                 fneg_r, fneg_nxt;
  logic signed [47:0]   afx_r, afy_r, afz_r, ae_r, fe_r;
  logic signed [47:0]   afx_nxt, afy_nxt, afz_nxt, ae_nxt, fe_nxt;
  logic                 outv_r, outv_nxt;
  logic [239:0]         outd_r, outd_nxt;

  // unit interfaces
  ljpf_pkg::mul_req_t   mreq;
  ljpf_pkg::unit_stat_t mstat, dstat;
  logic [63:0]          ma, mb, mres, dquo;
  logic                 dstart;

  ljpf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .req(mreq), .a(ma), .b(mb), .stat(mstat), .res(mres)
  );

  ljpf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .den(r2_r), .stat(dstat), .quo(dquo)
  );

  // derived terms
  logic signed [49:0] dcur;
  logic [49:0]        dmag;
  logic [63:0]        dclamp;
  logic [16:0]        kimg;
  logic signed [49:0] shv;
  logic signed [65:0] lj, et;
  logic [63:0]        ljm, etm;
  logic [63:0]        e24, e4;
  logic [64:0]        r2sum;
  logic               is_mul;
  logic signed [49:0] term, pe, ev;
  logic [49:0]        evm;

  always_comb begin
    dcur   = d_r[ax_r];
    dmag   = ljpf_pkg::mag50(dcur);
    dclamp = (dmag > 50'hFFFF_FFFF) ? 64'hFFFF_FFFF : 64'(dmag);
    kimg   = 17'(p_r[63:48]) + 17'(p_r[47]);
    shv    = $signed({2'b0, mres[47:0]});
    lj     = $signed({1'b0, ir12_r, 1'b0}) - $signed({2'b0, ir6_r});
    et     = $signed({2'b0, ir12_r}) - $signed({2'b0, ir6_r});
    ljm    = 64'(ljpf_pkg::mag66(lj));
    etm    = 64'(ljpf_pkg::mag66(et));
    e24    = {3'b0, 37'({eps_r, 4'b0}) + 37'({eps_r, 3'b0}), 24'b0};
    e4     = {6'b0, eps_r, 2'b0, 24'b0};
    r2sum  = 65'(r2_r) + 65'(mres);
    is_mul = (state_r == ljpf_pkg::S_P)  || (state_r == ljpf_pkg::S_K)  ||
             (state_r == ljpf_pkg::S_SQ) || (state_r == ljpf_pkg::S_M1) ||
             (state_r == ljpf_pkg::S_M2) || (state_r == ljpf_pkg::S_M3) ||
             (state_r == ljpf_pkg::S_M4) || (state_r == ljpf_pkg::S_M5) ||
             (state_r == ljpf_pkg::S_M6) || (state_r == ljpf_pkg::S_F);
  end

  // multiplier operand select
  always_comb begin
    ma        = '0;
    mb        = '0;
    mreq.mode = ljpf_pkg::MUL_SH40;
    case (state_r)
      ljpf_pkg::S_P: begin
        ma = 64'(dmag); mb = 64'(inv_box_r); mreq.mode = ljpf_pkg::MUL_PLAIN;
      end
      ljpf_pkg::S_K: begin
        ma = 64'(kimg); mb = 64'(box_r); mreq.mode = ljpf_pkg::MUL_PLAIN;
      end
      ljpf_pkg::S_SQ: begin
        ma = dclamp; mb = dclamp; mreq.mode = ljpf_pkg::MUL_PLAIN;
      end
      ljpf_pkg::S_M1: begin ma = ir2_r; mb = ir2_r; end
      ljpf_pkg::S_M2: begin ma = t_r;   mb = ir2_r; end
      ljpf_pkg::S_M3: begin ma = ir6_r; mb = ir6_r; end
      ljpf_pkg::S_M4: begin ma = e24;   mb = ir2_r; end
      ljpf_pkg::S_M5: begin ma = t_r;   mb = ljm; end
      ljpf_pkg::S_M6: begin
        ma = e4; mb = etm; mreq.mode = ljpf_pkg::MUL_SH56;
      end
      ljpf_pkg::S_F: begin
        ma = fm_r; mb = 64'(dmag); mreq.mode = ljpf_pkg::MUL_SH32;
      end
      default: ;
    endcase
    mreq.start = is_mul && !wait_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    wait_nxt  = wait_r;
    last_nxt  = last_r;
    dwr       = 1'b0;
    dcur_nxt  = dcur;
    p_nxt     = p_r;
    r2_nxt    = r2_r;
    ir2_nxt   = ir2_r;
    t_nxt     = t_r;
    ir6_nxt   = ir6_r;
    ir12_nxt  = ir12_r;
    fm_nxt    = fm_r;
    fneg_nxt  = fneg_r;
    afx_nxt   = afx_r;
    afy_nxt   = afy_r;
    afz_nxt   = afz_r;
    ae_nxt    = ae_r;
    fe_nxt    = fe_r;
    outv_nxt  = outv_r && !out_tready;
    outd_nxt  = outd_r;
    dstart    = 1'b0;
    in_tready = (state_r == ljpf_pkg::S_IDLE);
    term      = $signed(50'(mres[46:0]));
    if (fneg_r ^ dcur[49]) term = -term;
    pe        = $signed(50'(mres[46:0]));
    if (et[65]) pe = -pe;
    ev        = pe - 50'(eshift_r);
    evm       = ljpf_pkg::mag50(ev) >> 1;

    if (is_mul) begin
      if (!wait_r) wait_nxt = 1'b1;
      else if (mstat.done) wait_nxt = 1'b0;
    end

    case (state_r)
      ljpf_pkg::S_IDLE: begin
        if (in_tvalid) begin
          last_nxt  = in_tlast;
          ax_nxt    = '0;
          r2_nxt    = '0;
          if (in_tuser) fe_nxt = '0;
          state_nxt = ljpf_pkg::S_P;
        end
      end
      ljpf_pkg::S_P: if (wait_r && mstat.done) begin
        p_nxt     = mres;
        state_nxt = ljpf_pkg::S_K;
      end
      ljpf_pkg::S_K: if (wait_r && mstat.done) begin
        dwr       = 1'b1;
        dcur_nxt  = dcur[49] ? dcur + shv : dcur - shv;
        state_nxt = ljpf_pkg::S_SQ;
      end
      ljpf_pkg::S_SQ: if (wait_r && mstat.done) begin
        r2_nxt = r2sum[64] ? '1 : r2sum[63:0];
        if (ax_r == 2'd2) begin
          ax_nxt    = '0;
          state_nxt = ljpf_pkg::S_CHK;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = ljpf_pkg::S_P;
        end
      end
      ljpf_pkg::S_CHK: begin
        if (r2_r != '0 && r2_r < 64'(cutoff_r)) begin
          if (r2_r <= ljpf_pkg::RECIP_SAT_R2) begin
            ir2_nxt   = ljpf_pkg::CEIL62;
            state_nxt = ljpf_pkg::S_M1;
          end else begin
            dstart    = 1'b1;
            state_nxt = ljpf_pkg::S_DIV;
          end
        end else begin
          state_nxt = ljpf_pkg::S_FIN;
        end
      end
      ljpf_pkg::S_DIV: if (dstat.done) begin
        ir2_nxt   = dquo;
        state_nxt = ljpf_pkg::S_M1;
      end
      ljpf_pkg::S_M1: if (wait_r && mstat.done) begin
        t_nxt = mres; state_nxt = ljpf_pkg::S_M2;
      end
      ljpf_pkg::S_M2: if (wait_r && mstat.done) begin
        ir6_nxt = mres; state_nxt = ljpf_pkg::S_M3;
      end
      ljpf_pkg::S_M3: if (wait_r && mstat.done) begin
        ir12_nxt = mres; state_nxt = ljpf_pkg::S_M4;
      end
      ljpf_pkg::S_M4: if (wait_r && mstat.done) begin
        t_nxt = mres; state_nxt = ljpf_pkg::S_M5;
      end
      ljpf_pkg::S_M5: if (wait_r && mstat.done) begin
        fm_nxt    = mres;
        fneg_nxt  = lj[65];
        state_nxt = ljpf_pkg::S_M6;
      end
      ljpf_pkg::S_M6: if (wait_r && mstat.done) begin
        ae_nxt    = ljpf_pkg::sat_add48(ae_r, ev[49] ? -$signed(evm) : $signed(evm));
        ax_nxt    = '0;
        state_nxt = ljpf_pkg::S_F;
      end
      ljpf_pkg::S_F: if (wait_r && mstat.done) begin
        case (ax_r)
          2'd0:    afx_nxt = ljpf_pkg::sat_add48(afx_r, term);
          2'd1:    afy_nxt = ljpf_pkg::sat_add48(afy_r, term);
          default: afz_nxt = ljpf_pkg::sat_add48(afz_r, term);
        endcase
        if (ax_r == 2'd2) state_nxt = ljpf_pkg::S_FIN;
        else ax_nxt = ax_r + 2'd1;
      end
      ljpf_pkg::S_FIN: begin
        if (!last_r) begin
          state_nxt = ljpf_pkg::S_IDLE;
        end else if (!outv_r || out_tready) begin
          fe_nxt    = ljpf_pkg::sat_add48(fe_r, 50'(ae_r));
          outd_nxt  = {fe_nxt, ae_r, afz_r, afy_r, afx_r};
          outv_nxt  = 1'b1;
          afx_nxt   = '0;
          afy_nxt   = '0;
          afz_nxt   = '0;
          ae_nxt    = '0;
          state_nxt = ljpf_pkg::S_IDLE;
        end
      end
      default: state_nxt = ljpf_pkg::S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ljpf_pkg::S_IDLE;
      ax_r    <= '0;
      wait_r  <= 1'b0;
      last_r  <= 1'b0;
      afx_r   <= '0;
      afy_r   <= '0;
      afz_r   <= '0;
      ae_r    <= '0;
      fe_r    <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      wait_r  <= wait_nxt;
      last_r  <= last_nxt;
      afx_r   <= afx_nxt;
      afy_r   <= afy_nxt;
      afz_r   <= afz_nxt;
      ae_r    <= ae_nxt;
      fe_r    <= fe_nxt;
      outv_r  <= outv_nxt;
    end
    p_r    <= p_nxt;
    r2_r   <= r2_nxt;
    ir2_r  <= ir2_nxt;
    t_r    <= t_nxt;
    ir6_r  <= ir6_nxt;
    ir12_r <= ir12_nxt;
    fm_r   <= fm_nxt;
    fneg_r <= fneg_nxt;
    outd_r <= outd_nxt;
    if (state_r == ljpf_pkg::S_IDLE && in_tvalid) begin
      d_r[0] <= 50'($signed({in_tdata[31], in_tdata[31:0]}) -
                    $signed({in_tdata[127], in_tdata[127:96]}));
      d_r[1] <= 50'($signed({in_tdata[63], in_tdata[63:32]}) -
                    $signed({in_tdata[159], in_tdata[159:128]}));
      d_r[2] <= 50'($signed({in_tdata[95], in_tdata[95:64]}) -
                    $signed({in_tdata[191], in_tdata[191:160]}));
    end else if (dwr) begin
      d_r[ax_r] <= dcur_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r     <= 31'd65536;
      inv_box_r <= 32'hFFFF_FFFF;
      cutoff_r  <= 63'd27917287424;
      eps_r     <= 32'd65536;
      eshift_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ljpf_pkg::REG_BOX_LENGTH:     box_r     <= cfg_data[30:0];
        ljpf_pkg::REG_INV_BOX_LENGTH: inv_box_r <= cfg_data[31:0];
        ljpf_pkg::REG_CUTOFF_SQ:      cutoff_r  <= cfg_data[62:0];
        ljpf_pkg::REG_EPSILON:        eps_r     <= cfg_data[31:0];
        ljpf_pkg::REG_ENERGY_SHIFT:   eshift_r  <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = outv_r;
  assign out_tdata  = outd_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted a word while a pair was in flight");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.done |-> state_r == ljpf_pkg::S_DIV)
    else $error("divider result outside divide step");

  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ljpf_pkg::S_IDLE) |-> !mstat.busy)
    else $error("multiplier busy while idle");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> fe_r == '0)
    else $error("frame total not cleared on frame start");

endmodule
